@@ rtl/sst_pkg.sv @@
// Package: constants, payload types and the character-to-segment lookup of the scanner.
`default_nettype none
package sst_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int WPOS_W     = $clog2(NUM_DIGITS + 1);
    localparam int SCAN_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int SEG_W      = 8;
    localparam int ENABLE_W   = 4;

    localparam logic FUNC_TEXT = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [7:0] CHAR_NUL        = 8'h00;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] SEG_G     = 8'h40;
    localparam logic [SEG_W-1:0] SEG_D     = 8'h08;
    localparam logic [SEG_W-1:0] SEG_DP    = 8'h80;

    localparam logic [SEG_W-1:0] DIGIT_TABLE [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
        logic       first_char;
    } t_in_item;

    typedef struct packed {
        logic [SEG_W-1:0]    segments;
        logic [ENABLE_W-1:0] digit_enable;
    } t_out_item;

    function automatic logic [SEG_W-1:0] char_to_segments(input logic [7:0] c);
        logic [7:0] d;
        d = c - CHAR_ZERO;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            return DIGIT_TABLE[d[3:0]];
        end else if (c == CHAR_MINUS) begin
            return SEG_G;
        end else if (c == CHAR_UNDERSCORE) begin
            return SEG_D;
        end else begin
            return SEG_BLANK;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/seven_segment_text_scanner.sv @@
// Top level: multiplexed seven-segment text driver with scan-tick output.
// Every transaction passes through an input register, and a tick's result is written from
// there into an output register, which holds it until it is taken. One transaction is
// taken per cycle while no tick waits; a tick waits in the input register only while the
// output register holds an untaken result. Text transactions write the pattern store and
// give no result.
`default_nettype none
module seven_segment_text_scanner
    import sst_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output      logic      o_in_ready,
    input  wire t_in_item  i_in_data,
    output      logic      o_out_valid,
    input  wire logic      i_out_ready,
    output      t_out_item o_out_data
);

    logic                r_in_valid;
    t_in_item            r_in;
    logic                r_out_valid;
    t_out_item           r_out;
    logic [SEG_W-1:0]    r_pat [NUM_DIGITS];
    logic [SEG_W-1:0]    n_pat [NUM_DIGITS];
    logic [WPOS_W-1:0]   r_wpos;
    logic [WPOS_W-1:0]   n_wpos;
    logic [SCAN_W-1:0]   r_scan;
    logic [WPOS_W-1:0]   pos;
    logic                out_free;
    logic                stage_go;
    logic                text_go;
    logic                tick_go;

    assign out_free   = !r_out_valid || i_out_ready;
    assign stage_go   = r_in_valid && (r_in.func == FUNC_TEXT || out_free);
    assign text_go    = stage_go && r_in.func == FUNC_TEXT;
    assign tick_go    = stage_go && r_in.func == FUNC_TICK;
    assign o_in_ready = !r_in_valid || stage_go;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_pat  = r_pat;
        n_wpos = r_wpos;
        pos    = r_in.first_char ? '0 : r_wpos;
        if (pos < WPOS_W'(NUM_DIGITS)) begin
            if (r_in.char_code == CHAR_NUL) begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    if (WPOS_W'(i) >= pos) begin
                        n_pat[i] = SEG_BLANK;
                    end
                end
                n_wpos = WPOS_W'(NUM_DIGITS);
            end else if (r_in.char_code == CHAR_DOT && pos != '0) begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    if (WPOS_W'(i + 1) == pos) begin
                        n_pat[i] = r_pat[i] | SEG_DP;
                    end
                end
                n_wpos = pos;
            end else begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    if (WPOS_W'(i) == pos) begin
                        n_pat[i] = char_to_segments(r_in.char_code);
                    end
                end
                n_wpos = pos + WPOS_W'(1);
            end
        end else begin
            n_wpos = pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (tick_go) begin
            r_out.segments     <= r_pat[r_scan];
            r_out.digit_enable <= ENABLE_W'(1) << r_scan;
        end
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wpos      <= '0;
            r_scan      <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_pat[i] <= SEG_BLANK;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (tick_go) begin
                r_out_valid <= 1'b1;
                r_scan <= (r_scan == SCAN_W'(NUM_DIGITS - 1)) ? '0 : r_scan + SCAN_W'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (text_go) begin
                r_pat  <= n_pat;
                r_wpos <= n_wpos;
            end
        end
    end

    a_enable_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(o_out_data.digit_enable))
        else $error("digit enable not one-hot");

    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= WPOS_W'(NUM_DIGITS))
        else $error("write position out of range");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= SCAN_W'(NUM_DIGITS - 1))
        else $error("scan index out of range");

    a_text_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        text_go && out_free |=> !o_out_valid)
        else $error("text transaction produced a result");

endmodule
`default_nettype wire

@@ dv/sst_scoreboard_pkg.sv @@
// Scoreboard for the seven-segment text scanner: display state model and frame checks.
package sst_scoreboard_pkg;
    import sst_pkg::*;

    class display_scoreboard;
        logic [SEG_W-1:0]  glyphs [NUM_DIGITS];
        logic [WPOS_W-1:0] cursor;
        logic [SCAN_W-1:0] scan_pos;
        t_out_item         expected_frames [$];
        int unsigned       errors;
        int unsigned       text_seen;
        int unsigned       ticks_seen;
        int unsigned       frames_checked;
        int unsigned       applied;

        function new();
            foreach (glyphs[i]) glyphs[i] = SEG_BLANK;
            cursor         = '0;
            scan_pos       = '0;
            errors         = 0;
            text_seen      = 0;
            ticks_seen     = 0;
            frames_checked = 0;
            applied        = 0;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function logic [SEG_W-1:0] glyph_of(input logic [7:0] c);
            logic [3:0] d;
            d = c[3:0];
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                case (d)
                    4'd0:    return 8'h3F;
                    4'd1:    return 8'h06;
                    4'd2:    return 8'h5B;
                    4'd3:    return 8'h4F;
                    4'd4:    return 8'h66;
                    4'd5:    return 8'h6D;
                    4'd6:    return 8'h7D;
                    4'd7:    return 8'h07;
                    4'd8:    return 8'h7F;
                    default: return 8'h6F;
                endcase
            end else if (c == CHAR_MINUS) begin
                return SEG_G;
            end else if (c == CHAR_UNDERSCORE) begin
                return SEG_D;
            end
            return SEG_BLANK;
        endfunction

        task report(input string what, input int got, input int want);
            $display("ERROR: %s mismatch: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        function void note_transaction(input t_in_item item);
            t_out_item frame;
            if (item.func == FUNC_TICK) begin
                frame.segments               = glyphs[scan_pos];
                frame.digit_enable           = '0;
                frame.digit_enable[scan_pos] = 1'b1;
                expected_frames.push_back(frame);
                scan_pos = (scan_pos == SCAN_W'(NUM_DIGITS - 1)) ? '0 : scan_pos + 1'b1;
                ticks_seen++;
                applied++;
                return;
            end
            text_seen++;
            if (item.first_char) cursor = '0;
            if (cursor >= NUM_DIGITS) return;
            applied++;
            if (item.char_code == CHAR_NUL) begin
                for (int i = int'(cursor); i < NUM_DIGITS; i++) glyphs[i] = SEG_BLANK;
                cursor = WPOS_W'(NUM_DIGITS);
            end else if (item.char_code == CHAR_DOT && cursor != 0) begin
                glyphs[cursor - 1] = glyphs[cursor - 1] | SEG_DP;
            end else begin
                glyphs[cursor] = glyph_of(item.char_code);
                cursor         = cursor + 1'b1;
            end
        endfunction

        task check_frame(input t_out_item got);
            t_out_item want;
            if (expected_frames.size() == 0) begin
                report("unexpected frame", int'(got), 0);
                return;
            end
            want = expected_frames.pop_front();
            frames_checked++;
            if (got.segments !== want.segments)
                report("segments", int'(got.segments), int'(want.segments));
            if (got.digit_enable !== want.digit_enable)
                report("digit_enable", int'(got.digit_enable), int'(want.digit_enable));
        endtask
    endclass

endpackage

@@ dv/seven_segment_text_scanner_test.sv @@
// Testbench top: drives text and tick transactions into the scanner and checks every frame.
module seven_segment_text_scanner_test;
    import sst_pkg::*;
    import sst_scoreboard_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 10;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_STALL, RX_TOGGLE} t_rx_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    display_scoreboard sb = new();
    int                quiet_cycles = 0;
    int                burst_left   = 0;

    seven_segment_text_scanner u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_transaction(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_frame(o_out_data);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
    end

    initial begin
        t_rx_mode mode;
        int       len;
        int       stall_len;
        logic     v;
        wait (i_rst_n);
        forever begin
            mode      = t_rx_mode'($urandom_range(0, 3));
            len       = $urandom_range(4, 40);
            stall_len = $urandom_range(1, 12);
            for (int j = 0; j < len; j++) begin
                @(negedge i_clk);
                case (mode)
                    RX_OPEN:   v = 1'b1;
                    RX_RANDOM: v = 1'($urandom_range(0, 1));
                    RX_STALL:  v = (j >= stall_len);
                    default:   v = j[0];
                endcase
                i_out_ready <= v;
            end
        end
    end

    task idle_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task drain_display();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    task drive_item(input logic func, input logic [7:0] c, input logic first);
        t_in_item item;
        int       gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) gap = 0;
            else if ($urandom_range(0, 7) == 0) gap = $urandom_range(10, 20);
            else gap = $urandom_range(1, 4);
            if (gap > 0) idle_sender(gap);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item.func       = func;
        item.char_code  = c;
        item.first_char = first;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task send_text(input logic [7:0] c, input logic first);
        drive_item(FUNC_TEXT, c, first);
    endtask

    task send_tick();
        drive_item(FUNC_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task send_string(input string s, input logic start);
        for (int i = 0; i < s.len(); i++) send_text(s[i], start && i == 0);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 15);
        if (r <= 6) return CHAR_ZERO + 8'($urandom_range(0, 9));
        if (r == 7) return CHAR_MINUS;
        if (r == 8) return CHAR_UNDERSCORE;
        if (r <= 10) return CHAR_DOT;
        if (r == 11) return CHAR_NUL;
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int unsigned base;
        int          len;
        bit          drained;
        logic        first;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_string("7..-", 1'b0);
        send_text(CHAR_NUL, 1'b0);
        send_text("5", 1'b0);
        repeat (4) send_tick();
        send_string("._", 1'b1);
        send_text(8'hFF, 1'b0);
        send_string("93", 1'b0);
        repeat (4) drive_item(FUNC_TICK, 8'hFF, 1'b1);
        send_text("0", 1'b1);
        repeat (4) drive_item(FUNC_TICK, 8'h00, 1'b0);

        base    = sb.applied;
        drained = 1'b0;
        while (sb.applied - base < RANDOM_ITEMS) begin
            if (!drained && sb.applied - base >= RANDOM_ITEMS / 2) begin
                drain_display();
                drained = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++) begin
                        send_text(pick_char(), k == 0);
                        if ($urandom_range(0, 2) == 0) send_tick();
                    end
                end
                6, 7: begin
                    repeat ($urandom_range(1, 8)) send_tick();
                end
                8: begin
                    drive_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
                end
                default: begin
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++) begin
                        first = (k != 0) && ($urandom_range(0, 3) == 0);
                        send_text(pick_char(), first);
                    end
                end
            endcase
        end

        drain_display();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d text and %0d tick transactions; %0d frames checked.",
                 sb.text_seen, sb.ticks_seen, sb.frames_checked);
        $display("Mismatches reported: %0d", sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ seven_segment_text_scanner.f @@
rtl/sst_pkg.sv
rtl/seven_segment_text_scanner.sv
dv/sst_scoreboard_pkg.sv
dv/seven_segment_text_scanner_test.sv
